>>> hdl/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

  // Internal address pointer width; dest_addr carries its low 24 bits
  localparam int ADDR_BITS = 24;

  // Port field widths
  localparam int BYTE_W     = 8;
  localparam int DEST_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register field widths
  localparam int ROW_WIDTH_W   = 10;
  localparam int ROW_COUNT_W   = 10;
  localparam int PLANE_COUNT_W = 4;
  localparam int STRIDE_W      = 13;
  localparam int BASE_W        = 24;

  // Stream and counter widths
  localparam int RUN_LEN_W = 7;
  localparam int COLUMN_W  = 11;
  localparam int REP_FLAG  = 7;

  // At most this many pixels leave per stream byte
  localparam int BURST_MAX = 64;
  localparam int BURST_W   = $clog2(BURST_MAX);

  // Register reset values
  localparam logic [ROW_WIDTH_W-1:0]   ROW_WIDTH_RST   = 10'd80;
  localparam logic [ROW_COUNT_W-1:0]   ROW_COUNT_RST   = 10'd479;
  localparam logic [PLANE_COUNT_W-1:0] PLANE_COUNT_RST = 4'd1;
  localparam logic [STRIDE_W-1:0]      STRIDE_RST      = 13'd640;
  localparam logic [BASE_W-1:0]        BASE_RST        = 24'd0;

  typedef logic [ADDR_BITS-1:0] addr_t;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH   = 3'd0,
    CFG_ROW_COUNT   = 3'd1,
    CFG_PLANE_COUNT = 3'd2,
    CFG_LINE_STRIDE = 3'd3,
    CFG_BASE_OFFSET = 3'd4
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_byte;   // latch stream byte, clear done flag
    logic emit;        // push one pixel towards the output register
    logic emit_rep;    // pixel source: repeat pixel (else stream byte)
    logic emit_last;   // last pixel of this byte, held until finish
    logic dec_rep;     // one repeat pixel delivered
    logic dec_lit;     // one literal delivered
    logic ctrl_update; // act on a control byte
    logic load_rep;    // capture repeat pixel, restart burst count
    logic end_run;     // row end check and pointer step
    logic finish;      // release held pixel with its flags
  } rbd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rep_nz;
    logic rep_one;
    logic burst_last;
    logic byte_rep;
    logic byte_len_zero;
    logic lit_last;
    logic out_free;
  } rbd_status_t;

endpackage

>>> hdl/rbd_datapath.sv
`timescale 1ns / 1ps

module rbd_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // stream byte
  input  logic [rbd_pkg::BYTE_W-1:0]         in_byte,
  // control
  input  rbd_pkg::rbd_cmd_t                  cmd,
  output rbd_pkg::rbd_status_t               status,
  // result register
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [rbd_pkg::BYTE_W-1:0]         out_pixel,
  output logic [rbd_pkg::DEST_W-1:0]         out_dest_addr,
  output logic                               out_run_last,
  output logic                               out_image_done
);

  // Configuration registers
  logic [rbd_pkg::ROW_WIDTH_W-1:0]   row_width_r;
  logic [rbd_pkg::ROW_COUNT_W-1:0]   row_count_r;
  logic [rbd_pkg::PLANE_COUNT_W-1:0] plane_count_r;
  logic [rbd_pkg::STRIDE_W-1:0]      line_stride_r;
  logic [rbd_pkg::BASE_W-1:0]        base_offset_r;

  // Decoder state
  logic [rbd_pkg::BYTE_W-1:0]        byte_r;
  logic [rbd_pkg::BYTE_W-1:0]        rep_pixel_r,    rep_pixel_nxt;
  logic [rbd_pkg::RUN_LEN_W-1:0]     repeat_len_r,   repeat_len_nxt;
  logic [rbd_pkg::RUN_LEN_W-1:0]     literal_left_r, literal_left_nxt;
  logic [rbd_pkg::BURST_W-1:0]       burst_cnt_r,    burst_cnt_nxt;
  logic [rbd_pkg::COLUMN_W-1:0]      column_r,       column_nxt;
  logic [rbd_pkg::ROW_COUNT_W-1:0]   row_r,          row_nxt;
  logic [rbd_pkg::PLANE_COUNT_W-1:0] plane_r,        plane_nxt;
  rbd_pkg::addr_t                    write_addr_r,   write_addr_nxt;
  logic                              plane_start_r,  plane_start_nxt;
  logic                              done_r,         done_nxt;
  logic                              held_r,         held_nxt;

  // Output register
  logic                              out_valid_r,      out_valid_nxt;
  logic [rbd_pkg::BYTE_W-1:0]        out_pixel_r,      out_pixel_nxt;
  logic [rbd_pkg::DEST_W-1:0]        out_addr_r,       out_addr_nxt;
  logic                              out_run_last_r,   out_run_last_nxt;
  logic                              out_image_done_r, out_image_done_nxt;

  // Row end terms
  logic [rbd_pkg::ROW_COUNT_W-1:0]   rows_eff;
  logic [rbd_pkg::PLANE_COUNT_W-1:0] planes_eff;
  logic [rbd_pkg::ROW_COUNT_W:0]     row_inc;
  logic [rbd_pkg::PLANE_COUNT_W:0]   plane_inc;
  logic                              row_end;
  logic                              row_wrap;
  logic                              plane_wrap;
  rbd_pkg::addr_t                    addr_skip;

  logic [rbd_pkg::RUN_LEN_W-1:0]     ctrl_len;
  logic [rbd_pkg::BYTE_W-1:0]        emit_pix;
  logic                              out_xfer;

  assign ctrl_len   = byte_r[rbd_pkg::RUN_LEN_W-1:0];
  assign emit_pix   = cmd.emit_rep ? rep_pixel_r : byte_r;
  assign out_xfer   = out_valid_r && !out_stall;

  // Zero counts behave as one
  assign rows_eff   = (row_count_r == '0) ? rbd_pkg::ROW_COUNT_W'(1) : row_count_r;
  assign planes_eff = (plane_count_r == '0) ? rbd_pkg::PLANE_COUNT_W'(1) : plane_count_r;
  assign row_inc    = {1'b0, row_r} + 1'b1;
  assign plane_inc  = {1'b0, plane_r} + 1'b1;
  assign row_end    = column_r >= rbd_pkg::COLUMN_W'(row_width_r);
  assign row_wrap   = row_inc >= {1'b0, rows_eff};
  assign plane_wrap = plane_inc >= {1'b0, planes_eff};
  // Step to next screen line; modular, stride may be below width
  assign addr_skip  = write_addr_r + rbd_pkg::addr_t'(line_stride_r)
                      - rbd_pkg::addr_t'(row_width_r);

  // Status back to the controller
  assign status.rep_nz        = repeat_len_r != '0;
  assign status.rep_one       = repeat_len_r == rbd_pkg::RUN_LEN_W'(1);
  assign status.burst_last    = burst_cnt_r == rbd_pkg::BURST_W'(rbd_pkg::BURST_MAX - 1);
  assign status.byte_rep      = byte_r[rbd_pkg::REP_FLAG];
  assign status.byte_len_zero = ctrl_len == '0;
  assign status.lit_last      = literal_left_r <= rbd_pkg::RUN_LEN_W'(1);
  assign status.out_free      = !out_valid_r || !out_stall;

  // Decoder state update
  always_comb begin
    rep_pixel_nxt    = rep_pixel_r;
    repeat_len_nxt   = repeat_len_r;
    literal_left_nxt = literal_left_r;
    burst_cnt_nxt    = burst_cnt_r;
    column_nxt       = column_r;
    row_nxt          = row_r;
    plane_nxt        = plane_r;
    write_addr_nxt   = write_addr_r;
    plane_start_nxt  = plane_start_r;
    done_nxt         = done_r;

    if (cmd.take_byte) begin
      done_nxt = 1'b0;
    end
    if (cmd.load_rep) begin
      rep_pixel_nxt = byte_r;
      burst_cnt_nxt = '0;
    end
    if (cmd.emit) begin
      write_addr_nxt = write_addr_r + 1'b1;
    end
    if (cmd.dec_rep) begin
      repeat_len_nxt = repeat_len_r - 1'b1;
      burst_cnt_nxt  = burst_cnt_r + 1'b1;
    end
    if (cmd.dec_lit && (literal_left_r != '0)) begin
      literal_left_nxt = literal_left_r - 1'b1;
    end

    // Control byte: reload pointer at plane start, advance column, load run length
    if (cmd.ctrl_update) begin
      if (plane_start_r) begin
        write_addr_nxt  = rbd_pkg::addr_t'(base_offset_r);
        plane_start_nxt = 1'b0;
      end
      column_nxt = column_r + rbd_pkg::COLUMN_W'(ctrl_len);
      if (byte_r[rbd_pkg::REP_FLAG]) begin
        repeat_len_nxt = ctrl_len;
      end else if (ctrl_len != '0) begin
        literal_left_nxt = ctrl_len;
      end
    end

    // Row end: clear column, skip pointer to next line, step row, plane and image
    if (cmd.end_run && row_end) begin
      column_nxt     = '0;
      write_addr_nxt = addr_skip;
      if (!row_wrap) begin
        row_nxt = row_inc[rbd_pkg::ROW_COUNT_W-1:0];
      end else begin
        row_nxt         = '0;
        plane_start_nxt = 1'b1;
        if (!plane_wrap) begin
          plane_nxt = plane_inc[rbd_pkg::PLANE_COUNT_W-1:0];
        end else begin
          plane_nxt = '0;
          done_nxt  = 1'b1;
        end
      end
    end
  end

  // Output register; last pixel of a byte is held until its flags settle
  always_comb begin
    out_valid_nxt      = out_valid_r && !out_xfer;
    out_pixel_nxt      = out_pixel_r;
    out_addr_nxt       = out_addr_r;
    out_run_last_nxt   = out_run_last_r;
    out_image_done_nxt = out_image_done_r;
    held_nxt           = held_r;

    if (cmd.emit) begin
      out_pixel_nxt      = emit_pix;
      out_addr_nxt       = rbd_pkg::DEST_W'(write_addr_r);
      out_run_last_nxt   = cmd.emit_last;
      out_image_done_nxt = 1'b0;
      if (cmd.emit_last) begin
        held_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
    if (cmd.finish && held_r) begin
      out_valid_nxt      = 1'b1;
      out_image_done_nxt = done_r;
      held_nxt           = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= rbd_pkg::ROW_WIDTH_RST;
      row_count_r   <= rbd_pkg::ROW_COUNT_RST;
      plane_count_r <= rbd_pkg::PLANE_COUNT_RST;
      line_stride_r <= rbd_pkg::STRIDE_RST;
      base_offset_r <= rbd_pkg::BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbd_pkg::CFG_ROW_WIDTH:   row_width_r   <= cfg_data[rbd_pkg::ROW_WIDTH_W-1:0];
        rbd_pkg::CFG_ROW_COUNT:   row_count_r   <= cfg_data[rbd_pkg::ROW_COUNT_W-1:0];
        rbd_pkg::CFG_PLANE_COUNT: plane_count_r <= cfg_data[rbd_pkg::PLANE_COUNT_W-1:0];
        rbd_pkg::CFG_LINE_STRIDE: line_stride_r <= cfg_data[rbd_pkg::STRIDE_W-1:0];
        rbd_pkg::CFG_BASE_OFFSET: base_offset_r <= cfg_data[rbd_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      byte_r <= in_byte;
    end
    out_pixel_r      <= out_pixel_nxt;
    out_addr_r       <= out_addr_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_image_done_r <= out_image_done_nxt;
  end

  // Control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_pixel_r    <= '0;
      repeat_len_r   <= '0;
      literal_left_r <= '0;
      burst_cnt_r    <= '0;
      column_r       <= '0;
      row_r          <= '0;
      plane_r        <= '0;
      write_addr_r   <= '0;
      plane_start_r  <= 1'b1;
      done_r         <= 1'b0;
      held_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      rep_pixel_r    <= rep_pixel_nxt;
      repeat_len_r   <= repeat_len_nxt;
      literal_left_r <= literal_left_nxt;
      burst_cnt_r    <= burst_cnt_nxt;
      column_r       <= column_nxt;
      row_r          <= row_nxt;
      plane_r        <= plane_nxt;
      write_addr_r   <= write_addr_nxt;
      plane_start_r  <= plane_start_nxt;
      done_r         <= done_nxt;
      held_r         <= held_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_dest_addr  = out_addr_r;
  assign out_run_last   = out_run_last_r;
  assign out_image_done = out_image_done_r;

endmodule

>>> hdl/rbd_ctrl.sv
`timescale 1ns / 1ps

module rbd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rbd_pkg::rbd_status_t status,
  output rbd_pkg::rbd_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_WAIT,
    S_FLUSH,
    S_FLUSH_END,
    S_CTRL,
    S_REP_LOAD,
    S_REP_EMIT,
    S_LIT,
    S_END,
    S_FIN
  } state_t;

  // Meaning of the next stream byte
  typedef enum logic [1:0] {
    PH_CTRL,
    PH_REP,
    PH_LIT
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  assign in_stall = state_r != S_WAIT;

  // Sequencing and command decode
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;

    unique case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          unique case (phase_r)
            PH_REP:  state_nxt = S_REP_LOAD;
            PH_LIT:  state_nxt = S_LIT;
            default: state_nxt = S_FLUSH;
          endcase
        end
      end

      // Remainder of a long repeat goes out before the control byte
      S_FLUSH: begin
        if (!status.rep_nz) begin
          state_nxt = S_CTRL;
        end else if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_rep  = 1'b1;
          cmd.emit_last = status.rep_one;
          cmd.dec_rep   = 1'b1;
          if (status.rep_one) begin
            state_nxt = S_FLUSH_END;
          end
        end
      end

      S_FLUSH_END: begin
        cmd.end_run = 1'b1;
        state_nxt   = S_CTRL;
      end

      S_CTRL: begin
        cmd.ctrl_update = 1'b1;
        if (status.byte_rep) begin
          phase_nxt = PH_REP;
          state_nxt = S_FIN;
        end else if (status.byte_len_zero) begin
          phase_nxt = PH_CTRL;
          state_nxt = S_END;
        end else begin
          phase_nxt = PH_LIT;
          state_nxt = S_FIN;
        end
      end

      S_REP_LOAD: begin
        cmd.load_rep = 1'b1;
        phase_nxt    = PH_CTRL;
        state_nxt    = status.rep_nz ? S_REP_EMIT : S_END;
      end

      // Up to one burst of the run; a longer run ends on the next byte
      S_REP_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_rep  = 1'b1;
          cmd.emit_last = status.rep_one || status.burst_last;
          cmd.dec_rep   = 1'b1;
          if (status.rep_one) begin
            state_nxt = S_END;
          end else if (status.burst_last) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_LIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.dec_lit   = 1'b1;
          if (status.lit_last) begin
            phase_nxt = PH_CTRL;
            state_nxt = S_END;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_END: begin
        cmd.end_run = 1'b1;
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_WAIT;
      end

      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
      phase_r <= PH_CTRL;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> hdl/rle_bitmap_blit_decoder.sv
`timescale 1ns / 1ps

// Run-length bitmap decoder with destination address generation.
// Input channel (in_valid/in_stall/in_byte): one compressed stream byte per
// transfer; in_stall is low only while the block waits for the next byte.
// Output channel (out_valid/out_stall/out_*): one pixel per transfer with its
// address; out_run_last marks the last pixel caused by a stream byte and
// out_image_done marks it when the last row of the last plane has closed.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, writes belong between images or while idle.
// Sequencing by the state machine, without output stalls: after a transfer,
// in_stall stays high on a control byte for S_FLUSH (and S_FLUSH_END after a
// flush), S_CTRL, S_END on a zero-length literal, and S_FIN; on a literal byte
// for S_LIT, S_END on the last one, and S_FIN; on a repeat data byte giving N
// pixels (at most 64), one pixel per cycle, for S_REP_LOAD, S_REP_EMIT, S_END
// (not after a full burst) and S_FIN; the rest of a longer run leaves in
// S_FLUSH before the next control byte; a literal pixel is held until S_FIN.
// The output register lets the next byte be taken while a pixel waits.
// When the receiver stalls, the pixel sequence pauses and resumes in step.
// Reset restores the register defaults and starts a new image at plane 0.

module rle_bitmap_blit_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  // compressed stream
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rbd_pkg::BYTE_W-1:0]     in_byte,
  // decoded pixels
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rbd_pkg::BYTE_W-1:0]     out_pixel,
  output logic [rbd_pkg::DEST_W-1:0]     out_dest_addr,
  output logic                           out_run_last,
  output logic                           out_image_done
);

  rbd_pkg::rbd_cmd_t    cmd;
  rbd_pkg::rbd_status_t status;

  assign cfg_ready = 1'b1;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rbd_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_byte        (in_byte),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .out_dest_addr  (out_dest_addr),
    .out_run_last   (out_run_last),
    .out_image_done (out_image_done)
  );

endmodule
